[hdl/cpts_pkg.sv]
// cpts_pkg: shared types, constants and action codes for the task scheduler
// no dependencies

package cpts_pkg;

  localparam int unsigned TaskSlots = 64;
  localparam int unsigned IdxW = $clog2(TaskSlots);
  localparam int unsigned CntW = 9;
  localparam int unsigned PrioW = 8;
  localparam int unsigned TimeW = 32;
  localparam logic [CntW-1:0] CntMax = '1;

  typedef enum logic [3:0] {
    ACT_TICK    = 4'd0,
    ACT_SCHED   = 4'd1,
    ACT_PAUSE   = 4'd2,
    ACT_BLOCK   = 4'd3,
    ACT_WAKE    = 4'd4,
    ACT_SIGNAL  = 4'd5,
    ACT_ALARM   = 4'd6,
    ACT_NICE    = 4'd7,
    ACT_INSTALL = 4'd8,
    ACT_REMOVE  = 4'd9
  } action_e;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StBadSlot = 2'd1;
  localparam logic [1:0] StIdleSleep = 2'd2;
  localparam logic [1:0] StNiceRej = 2'd3;

  localparam logic [1:0] RsRun = 2'd0;
  localparam logic [1:0] RsIntr = 2'd1;
  localparam logic [1:0] RsUnintr = 2'd2;

  // operation broadcast along the cell chain
  typedef enum logic [3:0] {
    COP_NONE    = 4'd0,
    COP_TICK    = 4'd1,
    COP_SETRS   = 4'd2,
    COP_WAKE    = 4'd3,
    COP_SIGNAL  = 4'd4,
    COP_ALARM   = 4'd5,
    COP_NICE    = 4'd6,
    COP_INSTALL = 4'd7,
    COP_REMOVE  = 4'd8,
    COP_SWEEP   = 4'd9,
    COP_REFILL  = 4'd10
  } cop_e;

  typedef struct packed {
    cop_e             op;
    logic [IdxW-1:0]  idx;
    logic [1:0]       rs;
    logic             flag;
    logic [PrioW-1:0] prio;
    logic [TimeW-1:0] time_v;
  } cell_cmd_t;

  // running best carried along the chain during a pick
  typedef struct packed {
    logic            found;
    logic [CntW-1:0] cnt;
    logic [IdxW-1:0] idx;
  } pick_t;

endpackage

[hdl/cpts_cell.sv]
// cpts_cell: one task slot, state and per-slot update logic
// depends on cpts_pkg; chained by cpts_chain

module cpts_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [cpts_pkg::IdxW-1:0]  slot_i,
  input  cpts_pkg::cell_cmd_t        cmd_i,
  input  logic                       cmd_en_i,
  input  logic [cpts_pkg::TimeW-1:0] ticks_i,
  input  cpts_pkg::pick_t            pick_i,
  output cpts_pkg::pick_t            pick_o,
  output logic                       used_o,
  output logic [cpts_pkg::PrioW-1:0] prio_o,
  output logic [cpts_pkg::CntW-1:0]  cnt_o
);

  logic                       used_q, used_d;
  logic [1:0]                 rs_q, rs_d;
  logic [cpts_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [cpts_pkg::PrioW-1:0] prio_q, prio_d;
  logic [cpts_pkg::TimeW-1:0] alarm_q, alarm_d;
  logic                       sig_q, sig_d;
  logic                       hit;
  logic                       fire;
  logic [cpts_pkg::CntW:0]    refill;

  assign hit = (cmd_i.idx == slot_i);
  assign fire = (alarm_q != '0) && (alarm_q < ticks_i) && (slot_i != '0);
  assign refill = {2'b0, cnt_q[cpts_pkg::CntW-1:1]} + {2'b0, prio_q};

  // slot update
  always_comb begin
    used_d = used_q;
    rs_d = rs_q;
    cnt_d = cnt_q;
    prio_d = prio_q;
    alarm_d = alarm_q;
    sig_d = sig_q;
    if (cmd_en_i) begin
      case (cmd_i.op)
        cpts_pkg::COP_TICK: begin
          if (hit && cnt_q != '0) cnt_d = cnt_q - 1'b1;
        end
        cpts_pkg::COP_SETRS: begin
          if (hit) rs_d = cmd_i.rs;
        end
        cpts_pkg::COP_WAKE: begin
          if (hit) rs_d = cpts_pkg::RsRun;
        end
        cpts_pkg::COP_SIGNAL: begin
          if (hit) sig_d = cmd_i.flag;
        end
        cpts_pkg::COP_ALARM: begin
          if (hit) alarm_d = cmd_i.time_v;
        end
        cpts_pkg::COP_NICE: begin
          if (hit) prio_d = cmd_i.prio;
        end
        cpts_pkg::COP_INSTALL: begin
          if (hit) begin
            used_d = 1'b1;
            rs_d = cpts_pkg::RsRun;
            prio_d = cmd_i.prio;
            cnt_d = {1'b0, cmd_i.prio};
            alarm_d = '0;
            sig_d = 1'b0;
          end
        end
        cpts_pkg::COP_REMOVE: begin
          if (hit) begin
            used_d = 1'b0;
            rs_d = cpts_pkg::RsRun;
            prio_d = '0;
            cnt_d = '0;
            alarm_d = '0;
            sig_d = 1'b0;
          end
        end
        cpts_pkg::COP_SWEEP: begin
          if (used_q && slot_i != '0) begin
            if (fire) begin
              sig_d = 1'b1;
              alarm_d = '0;
            end
            if ((fire || sig_q) && rs_q == cpts_pkg::RsIntr) rs_d = cpts_pkg::RsRun;
          end
        end
        cpts_pkg::COP_REFILL: begin
          if (used_q && slot_i != '0) begin
            cnt_d = refill[cpts_pkg::CntW] ? cpts_pkg::CntMax
                                           : refill[cpts_pkg::CntW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // pick: candidate wins on greater-or-equal, chain runs from low to high slot
  always_comb begin
    pick_o = pick_i;
    if (used_q && rs_q == cpts_pkg::RsRun && slot_i != '0 &&
        (!pick_i.found || cnt_q >= pick_i.cnt)) begin
      pick_o.found = 1'b1;
      pick_o.cnt = cnt_q;
      pick_o.idx = slot_i;
    end
  end

  assign used_o = used_q;
  assign prio_o = prio_q;
  assign cnt_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= (slot_i == '0);
      rs_q <= cpts_pkg::RsRun;
      cnt_q <= (slot_i == '0) ? cpts_pkg::CntW'(15) : '0;
      prio_q <= (slot_i == '0) ? cpts_pkg::PrioW'(15) : '0;
      alarm_q <= '0;
      sig_q <= 1'b0;
    end else begin
      used_q <= used_d;
      rs_q <= rs_d;
      cnt_q <= cnt_d;
      prio_q <= prio_d;
      alarm_q <= alarm_d;
      sig_q <= sig_d;
    end
  end

endmodule

[hdl/cpts_chain.sv]
// cpts_chain: row of slot cells with a registered pick chain cut in segments
// depends on cpts_pkg and cpts_cell

module cpts_chain (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cpts_pkg::cell_cmd_t             cmd_i,
  input  logic                            cmd_en_i,
  input  logic [cpts_pkg::TimeW-1:0]      ticks_i,
  input  logic                            pick_start_i,
  output logic                            pick_done_o,
  output cpts_pkg::pick_t                 pick_o,
  output logic [cpts_pkg::TaskSlots-1:0]  used_o,
  output logic [cpts_pkg::PrioW-1:0]      prio_o [cpts_pkg::TaskSlots],
  output logic [cpts_pkg::CntW-1:0]       cnt_o [cpts_pkg::TaskSlots]
);

  localparam int unsigned SegLen = 8;
  localparam int unsigned Segs = (cpts_pkg::TaskSlots + SegLen - 1) / SegLen;
  localparam int unsigned SegW = (Segs > 1) ? $clog2(Segs + 1) : 1;

  cpts_pkg::pick_t link [cpts_pkg::TaskSlots+1];
  cpts_pkg::pick_t seg_q [Segs+1];
  logic [SegW-1:0] seg_cnt_q;
  logic            busy_q;

  // chain input of each segment comes from the registered previous segment
  for (genvar s = 0; s < Segs; s++) begin : g_seg
    for (genvar k = 0; k < SegLen; k++) begin : g_cell
      if (s * SegLen + k < cpts_pkg::TaskSlots) begin : g_live
        localparam int unsigned Slot = s * SegLen + k;
        cpts_pkg::pick_t pick_in;
        if (k == 0) begin : g_head
          assign pick_in = seg_q[s];
        end else begin : g_body
          assign pick_in = link[Slot];
        end
        cpts_cell u_cell (
          .clk_i   (clk_i),
          .rst_ni  (rst_ni),
          .slot_i  (cpts_pkg::IdxW'(Slot)),
          .cmd_i   (cmd_i),
          .cmd_en_i(cmd_en_i),
          .ticks_i (ticks_i),
          .pick_i  (pick_in),
          .pick_o  (link[Slot+1]),
          .used_o  (used_o[Slot]),
          .prio_o  (prio_o[Slot]),
          .cnt_o   (cnt_o[Slot])
        );
      end
    end
  end

  // segment sequencer: one segment result registered per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      seg_cnt_q <= '0;
      for (int s = 0; s <= Segs; s++) seg_q[s] <= '0;
    end else if (pick_start_i) begin
      busy_q <= 1'b1;
      seg_cnt_q <= '0;
      seg_q[0] <= '0;
    end else if (busy_q) begin
      for (int s = 0; s < Segs; s++) begin
        if (seg_cnt_q == SegW'(s)) begin
          seg_q[s+1] <= link[(s + 1) * SegLen < cpts_pkg::TaskSlots ?
                             (s + 1) * SegLen : cpts_pkg::TaskSlots];
        end
      end
      seg_cnt_q <= seg_cnt_q + 1'b1;
      if (seg_cnt_q == SegW'(Segs - 1)) busy_q <= 1'b0;
    end
  end

  assign pick_done_o = busy_q && (seg_cnt_q == SegW'(Segs - 1));
  assign pick_o = link[cpts_pkg::TaskSlots];

endmodule

[hdl/counter_priority_task_scheduler.sv]
// counter_priority_task_scheduler: top level, event sequencer over the slot chain
// depends on cpts_pkg and cpts_chain
//
// usage: drive the request fields and raise start while busy is low; the
// request is taken at that edge. one result appears on current_task_o,
// switched_o, refilled_o and status_o for one cycle, flagged by done_o, and
// must be captured then since the receiver cannot stall the block.
// the user must write ticks_per_second_wdata_i with ticks_per_second_we_i only
// while idle; the block itself does not enforce it. steps: a request without a
// schedule goes through decode, cell update and result. a schedule adds an
// alarm sweep and a pick that walks the chain one 8-slot segment a cycle; a
// refill adds a refill step and a second pick. the alarm request adds a
// registered multiply step. one request at a time; busy is high from
// acceptance through the result cycle.
// reset: slot 0 (idle task) is installed with counter and priority 15,
// all others empty, tick count 0, ticks per second 100.

module counter_priority_task_scheduler (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            ticks_per_second_we_i,
  input  logic [9:0]                      ticks_per_second_wdata_i,
  input  logic [3:0]                      action_i,
  input  logic [cpts_pkg::IdxW-1:0]       task_index_i,
  input  logic                            user_mode_i,
  input  logic [15:0]                     alarm_seconds_i,
  input  logic signed [8:0]               nice_step_i,
  input  logic [7:0]                      start_priority_i,
  input  logic                            pending_i,
  output logic                            done_o,
  output logic [cpts_pkg::IdxW-1:0]       current_task_o,
  output logic                            switched_o,
  output logic                            refilled_o,
  output logic [1:0]                      status_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_DECODE = 8'b00000010,
    S_MUL    = 8'b00000100,
    S_APPLY  = 8'b00001000,
    S_SWEEP  = 8'b00010000,
    S_PICK   = 8'b00100000,
    S_REFILL = 8'b01000000,
    S_DONE   = 8'b10000000
  } state_e;

  state_e                     state_q, state_d;
  logic [9:0]                 tps_q;
  logic [cpts_pkg::TimeW-1:0] ticks_q, ticks_d;
  logic [cpts_pkg::IdxW-1:0]  run_q, run_d;
  logic [3:0]                 act_q;
  logic [cpts_pkg::IdxW-1:0]  idx_q;
  logic                       um_q;
  logic [15:0]                secs_q;
  logic signed [8:0]          nice_q;
  logic [7:0]                 sprio_q;
  logic                       pend_q;
  logic [25:0]                prod_q;
  logic                       pass_q, pass_d;
  logic                       sw_q, sw_d;
  logic                       rf_q, rf_d;
  logic [1:0]                 st_q, st_d;

  cpts_pkg::cell_cmd_t cmd;
  logic                cmd_en;
  logic                pick_start;
  logic                pick_done;
  cpts_pkg::pick_t     pick;
  logic [cpts_pkg::TaskSlots-1:0] used;
  logic [cpts_pkg::PrioW-1:0] prio [cpts_pkg::TaskSlots];
  logic [cpts_pkg::CntW-1:0]  cnt [cpts_pkg::TaskSlots];
  logic                       tgt_used;
  logic signed [10:0]         new_prio;
  logic [cpts_pkg::TimeW-1:0] alarm_sum;

  cpts_chain u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_en_i    (cmd_en),
    .ticks_i     (ticks_q),
    .pick_start_i(pick_start),
    .pick_done_o (pick_done),
    .pick_o      (pick),
    .used_o      (used),
    .prio_o      (prio),
    .cnt_o       (cnt)
  );

  assign tgt_used = used[idx_q];
  assign new_prio = $signed({3'b0, prio[run_q]}) - 11'(nice_q);
  assign alarm_sum = ticks_q + {6'b0, prod_q};

  // event sequencer
  always_comb begin
    state_d = state_q;
    ticks_d = ticks_q;
    run_d = run_q;
    pass_d = pass_q;
    sw_d = sw_q;
    rf_d = rf_q;
    st_d = st_q;
    cmd = '0;
    cmd.op = cpts_pkg::COP_NONE;
    cmd.idx = run_q;
    cmd_en = 1'b0;
    pick_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) state_d = S_DECODE;
      end
      S_DECODE: begin
        sw_d = 1'b0;
        rf_d = 1'b0;
        st_d = cpts_pkg::StOk;
        pass_d = 1'b0;
        state_d = (act_q == cpts_pkg::ACT_ALARM) ? S_MUL : S_APPLY;
      end
      S_MUL: state_d = S_APPLY;
      S_APPLY: begin
        cmd_en = 1'b1;
        state_d = S_DONE;
        case (act_q)
          cpts_pkg::ACT_TICK: begin
            cmd.op = cpts_pkg::COP_TICK;
            ticks_d = ticks_q + 1'b1;
            if (cnt[run_q] <= cpts_pkg::CntW'(1) && um_q) state_d = S_SWEEP;
          end
          cpts_pkg::ACT_SCHED: state_d = S_SWEEP;
          cpts_pkg::ACT_PAUSE: begin
            cmd.op = cpts_pkg::COP_SETRS;
            cmd.rs = cpts_pkg::RsIntr;
            state_d = S_SWEEP;
          end
          cpts_pkg::ACT_BLOCK: begin
            if (run_q == '0) st_d = cpts_pkg::StIdleSleep;
            else begin
              cmd.op = cpts_pkg::COP_SETRS;
              cmd.rs = cpts_pkg::RsUnintr;
              state_d = S_SWEEP;
            end
          end
          cpts_pkg::ACT_WAKE: begin
            cmd.idx = idx_q;
            if (!tgt_used) st_d = cpts_pkg::StBadSlot;
            else cmd.op = cpts_pkg::COP_WAKE;
          end
          cpts_pkg::ACT_SIGNAL: begin
            cmd.idx = idx_q;
            cmd.flag = pend_q;
            if (!tgt_used) st_d = cpts_pkg::StBadSlot;
            else cmd.op = cpts_pkg::COP_SIGNAL;
          end
          cpts_pkg::ACT_ALARM: begin
            cmd.op = cpts_pkg::COP_ALARM;
            cmd.time_v = (secs_q != '0) ? alarm_sum : '0;
          end
          cpts_pkg::ACT_NICE: begin
            cmd.prio = new_prio[7:0];
            if (new_prio > 0 && new_prio <= 255) cmd.op = cpts_pkg::COP_NICE;
            else st_d = cpts_pkg::StNiceRej;
          end
          cpts_pkg::ACT_INSTALL: begin
            cmd.idx = idx_q;
            cmd.prio = (sprio_q == '0) ? 8'd1 : sprio_q;
            if (idx_q == '0 || tgt_used) st_d = cpts_pkg::StBadSlot;
            else cmd.op = cpts_pkg::COP_INSTALL;
          end
          cpts_pkg::ACT_REMOVE: begin
            cmd.idx = idx_q;
            if (idx_q == '0 || !tgt_used) st_d = cpts_pkg::StBadSlot;
            else begin
              cmd.op = cpts_pkg::COP_REMOVE;
              if (idx_q == run_q) state_d = S_SWEEP;
            end
          end
          default: ;
        endcase
      end
      S_SWEEP: begin
        cmd.op = cpts_pkg::COP_SWEEP;
        cmd_en = 1'b1;
        sw_d = 1'b1;
        pick_start = 1'b1;
        state_d = S_PICK;
      end
      S_PICK: begin
        if (pick_done) begin
          if (pick.found && (pick.cnt == '0) && !pass_q) begin
            state_d = S_REFILL;
          end else begin
            run_d = pick.found ? pick.idx : '0;
            state_d = S_DONE;
          end
        end
      end
      S_REFILL: begin
        cmd.op = cpts_pkg::COP_REFILL;
        cmd_en = 1'b1;
        rf_d = 1'b1;
        pass_d = 1'b1;
        pick_start = 1'b1;
        state_d = S_PICK;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tps_q <= 10'd100;
      ticks_q <= '0;
      run_q <= '0;
      pass_q <= 1'b0;
      sw_q <= 1'b0;
      rf_q <= 1'b0;
      st_q <= cpts_pkg::StOk;
    end else begin
      state_q <= state_d;
      ticks_q <= ticks_d;
      run_q <= run_d;
      pass_q <= pass_d;
      sw_q <= sw_d;
      rf_q <= rf_d;
      st_q <= st_d;
      if (ticks_per_second_we_i) tps_q <= ticks_per_second_wdata_i;
    end
  end

  // request capture and alarm product
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      act_q <= action_i;
      idx_q <= task_index_i;
      um_q <= user_mode_i;
      secs_q <= alarm_seconds_i;
      nice_q <= nice_step_i;
      sprio_q <= start_priority_i;
      pend_q <= pending_i;
    end
    prod_q <= tps_q * secs_q;
  end

  assign busy = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);
  assign current_task_o = run_q;
  assign switched_o = sw_q;
  assign refilled_o = rf_q;
  assign status_o = st_q;

  // checks
  a_refill_implies_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!refilled_o || switched_o)) else $error("refill without switch");
  a_idle_slot_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used[0]) else $error("idle slot lost");
  a_run_slot_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> used[current_task_o]) else $error("running task not in table");
  a_done_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result held more than one cycle");

endmodule
